// ----- sv/bsc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the barometric compensation core.
package bsc_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOCAL = 2'd1;
  localparam logic [1:0] ST_ZDIV  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;
  localparam logic [2:0] REG_CAL     = 3'd6;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Compensation constants.
  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] P_COEF_SQ   = 32'd3038;
  localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_COEF_OFS  = 32'd3791;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] B4_OFFSET   = 32'd32768;
  localparam logic [19:0] PRESS_MAX   = 20'hF_FFFF;

  // One classified transaction as it travels from front to back.
  typedef struct packed {
    logic [31:0] x1;
    logic [31:0] den;
    logic [23:0] rawp;
    logic [1:0]  status;
  } queue_entry_t;

  // Low 32 bits of a product.
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    r = a * b;
    return r;
  endfunction

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    logic [31:0] r;
    r = 32'($signed(v) >>> s);
    return r;
  endfunction

  // Sign extension of a 16-bit half.
  function automatic logic [31:0] sx16(input logic [15:0] h);
    logic [31:0] r;
    r = {{16{h[15]}}, h};
    return r;
  endfunction

endpackage

// ----- sv/bsc_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage, with side payload.
module bsc_div #(
  parameter int unsigned Width = 32,
  parameter int unsigned PayW  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  input  logic [PayW-1:0]  payload_i,
  output logic             out_valid_o,
  output logic [Width-1:0] quotient_o,
  output logic [PayW-1:0]  payload_o
);

  logic             vld_q [Width];
  logic [Width-1:0] num_q [Width];
  logic [PayW-1:0]  pay_q [Width];
  logic [Width-1:0] rem_q [Width-1];
  logic [Width-1:0] div_q [Width-1];

  for (genvar s = 0; s < Width; s++) begin : g_stage
    logic             vld_in;
    logic [Width-1:0] num_in;
    logic [Width-1:0] rem_in;
    logic [Width-1:0] div_in;
    logic [PayW-1:0]  pay_in;
    logic [Width:0]   trial;
    logic [Width:0]   diff;

    if (s == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign num_in = dividend_i;
      assign rem_in = '0;
      assign div_in = divisor_i;
      assign pay_in = payload_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign div_in = div_q[s-1];
      assign pay_in = pay_q[s-1];
    end

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_in, num_in[Width-1]};
    assign diff  = trial - {1'b0, div_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    // Quotient bits collect in the low end of the dividend register.
    always_ff @(posedge clk_i) begin
      num_q[s] <= {num_in[Width-2:0], ~diff[Width]};
      pay_q[s] <= pay_in;
    end

    if (s < Width - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (!diff[Width]) begin
          rem_q[s] <= diff[Width-1:0];
        end else begin
          rem_q[s] <= trial[Width-1:0];
        end
        div_q[s] <= div_in;
      end
    end
  end

  assign out_valid_o = vld_q[Width-1];
  assign quotient_o  = num_q[Width-1];
  assign payload_o   = pay_q[Width-1];

endmodule

// ----- sv/bsc_front.sv -----
// Front part: accepts raw readings, computes X1 and the temperature divisor, classifies.
module bsc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [15:0]           raw_temperature_i,
  input  logic [23:0]           raw_pressure_bytes_i,
  input  logic [31:0]           coef_ac5_ac6_i,
  input  logic [31:0]           coef_mc_md_i,
  input  logic                  cal_loaded_i,
  output logic                  push_o,
  output bsc_pkg::queue_entry_t entry_o
);

  logic        vld_q;
  logic [31:0] prod_q;
  logic [23:0] rawp_q;
  logic [31:0] x1;
  logic [31:0] den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  // (UT - AC6) * AC5, low word.
  always_ff @(posedge clk_i) begin
    prod_q <= bsc_pkg::mul32({16'd0, raw_temperature_i} - {16'd0, coef_ac5_ac6_i[15:0]},
                             {16'd0, coef_ac5_ac6_i[31:16]});
    rawp_q <= raw_pressure_bytes_i;
  end

  // Classify the transaction before it enters the queue.
  always_comb begin
    x1  = bsc_pkg::asr32(prod_q, 15);
    den = x1 + bsc_pkg::sx16(coef_mc_md_i[15:0]);
    entry_o.x1   = x1;
    entry_o.den  = den;
    entry_o.rawp = rawp_q;
    if (!cal_loaded_i) begin
      entry_o.status = bsc_pkg::ST_NOCAL;
    end else if (den == 32'd0) begin
      entry_o.status = bsc_pkg::ST_ZDIV;
    end else begin
      entry_o.status = bsc_pkg::ST_OK;
    end
  end

  assign push_o = vld_q;

endmodule

// ----- sv/bsc_queue.sv -----
// Short queue of classified transactions between the front and back parts.
module bsc_queue #(
  parameter int unsigned Depth = bsc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bsc_pkg::queue_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  nonempty_o,
  output logic                  full_o,
  output bsc_pkg::queue_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsc_pkg::queue_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign do_pop     = pop_i && (cnt_q != '0);
  assign nonempty_o = (cnt_q != '0);
  assign full_o     = (cnt_q == CntW'(Depth));
  assign entry_o    = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- sv/bsc_back.sv -----
// Back part: temperature division, pressure polynomial, pressure division and saturation.
module bsc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  bsc_pkg::queue_entry_t entry_i,
  input  logic [31:0]           coef_ac1_ac2_i,
  input  logic [31:0]           coef_ac3_ac4_i,
  input  logic [31:0]           coef_b1_b2_i,
  input  logic [31:0]           coef_mc_md_i,
  input  logic [1:0]            oss_i,
  output logic                  done_o,
  output logic signed [15:0]    temperature_tenths_o,
  output logic [19:0]           pressure_pa_o,
  output logic [1:0]            status_o
);

  localparam int unsigned Pay1W = 32 + 24 + 2 + 1;
  localparam int unsigned Pay2W = 16 + 2 + 1;

  // Temperature division on magnitudes.
  logic [31:0]      mc_s, num_mag, den_mag;
  logic             neg;
  logic             d1_vld;
  logic [31:0]      d1_q;
  logic [Pay1W-1:0] d1_pay;
  logic [31:0]      d1_x1;
  logic [23:0]      d1_rawp;
  logic [1:0]       d1_st;
  logic             d1_neg;

  assign mc_s    = bsc_pkg::sx16(coef_mc_md_i[31:16]) << 11;
  assign neg     = mc_s[31] ^ entry_i.den[31];
  assign num_mag = mc_s[31] ? (32'd0 - mc_s) : mc_s;
  assign den_mag = entry_i.den[31] ? (32'd0 - entry_i.den) : entry_i.den;

  bsc_div #(.Width(32), .PayW(Pay1W)) u_div_t (
    .clk_i,
    .rst_ni,
    .in_valid_i  (valid_i),
    .dividend_i  (num_mag),
    .divisor_i   (den_mag),
    .payload_i   ({entry_i.x1, entry_i.rawp, entry_i.status, neg}),
    .out_valid_o (d1_vld),
    .quotient_o  (d1_q),
    .payload_o   (d1_pay)
  );

  assign {d1_x1, d1_rawp, d1_st, d1_neg} = d1_pay;

  // Pipeline registers of the pressure polynomial.
  logic        p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q, p5_vld_q;
  logic [15:0] p1_t_q, p2_t_q, p3_t_q, p4_t_q, p5_t_q;
  logic [1:0]  p1_st_q, p2_st_q, p3_st_q, p4_st_q, p5_st_q;
  logic [31:0] p1_up_q, p2_up_q, p3_up_q, p4_up_q;
  logic [31:0] p1_b6_q;
  logic [31:0] p2_sq_q, p2_ac2_q, p2_ac3_q;
  logic [31:0] p3_x1_q, p3_x2_q, p3_ac2_q, p3_ac3_q;
  logic [31:0] p4_b3_q, p4_x3_q;
  logic [31:0] p5_b4_q, p5_b7_q;

  logic [31:0] x2t, b5, tw;
  logic [15:0] tsat;
  logic [31:0] b3_sum, b3, x3, b4, b7;
  logic [1:0]  st5;

  // Stage 1: B5, saturated temperature, B6 and UP.
  always_comb begin
    x2t = d1_neg ? (32'd0 - d1_q) : d1_q;
    b5  = d1_x1 + x2t;
    tw  = bsc_pkg::asr32(b5 + 32'd8, 4);
    if (d1_st != bsc_pkg::ST_OK) begin
      tsat = 16'd0;
    end else if (tw[31] && (tw[30:15] != 16'hFFFF)) begin
      tsat = 16'h8000;
    end else if (!tw[31] && (tw[30:15] != 16'h0000)) begin
      tsat = 16'h7FFF;
    end else begin
      tsat = tw[15:0];
    end
  end

  // Stage 4 and 5 arithmetic.
  always_comb begin
    b3_sum = (coef_ac1_ac2_i[31:16] == 16'd0) ? p3_x1_q + p3_ac2_q
           : (bsc_pkg::sx16(coef_ac1_ac2_i[31:16]) << 2) + p3_x1_q + p3_ac2_q;
    b3     = bsc_pkg::asr32((b3_sum << oss_i) + 32'd2, 2);
    x3     = bsc_pkg::asr32(p3_ac3_q + p3_x2_q + 32'd2, 2);
    b4     = bsc_pkg::mul32({16'd0, coef_ac3_ac4_i[15:0]}, p4_x3_q + bsc_pkg::B4_OFFSET) >> 15;
    b7     = bsc_pkg::mul32(p4_up_q - p4_b3_q, bsc_pkg::B7_SCALE >> oss_i);
    st5    = ((p4_st_q == bsc_pkg::ST_OK) && (b4 == 32'd0)) ? bsc_pkg::ST_ZDIV : p4_st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= d1_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage 1.
    p1_t_q  <= tsat;
    p1_st_q <= d1_st;
    p1_b6_q <= b5 - bsc_pkg::B6_OFFSET;
    p1_up_q <= {8'd0, d1_rawp >> (4'd8 - {2'd0, oss_i})};
    // Stage 2: B6 squared and the B6 products.
    p2_t_q   <= p1_t_q;
    p2_st_q  <= p1_st_q;
    p2_up_q  <= p1_up_q;
    p2_sq_q  <= bsc_pkg::asr32(bsc_pkg::mul32(p1_b6_q, p1_b6_q), 12);
    p2_ac2_q <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef_ac1_ac2_i[15:0]), p1_b6_q), 11);
    p2_ac3_q <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef_ac3_ac4_i[31:16]), p1_b6_q), 13);
    // Stage 3: products of the squared term.
    p3_t_q   <= p2_t_q;
    p3_st_q  <= p2_st_q;
    p3_up_q  <= p2_up_q;
    p3_ac2_q <= p2_ac2_q;
    p3_ac3_q <= p2_ac3_q;
    p3_x1_q  <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef_b1_b2_i[15:0]), p2_sq_q), 11);
    p3_x2_q  <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef_b1_b2_i[31:16]), p2_sq_q), 16);
    // Stage 4: B3 and X3.
    p4_t_q  <= p3_t_q;
    p4_st_q <= p3_st_q;
    p4_up_q <= p3_up_q;
    p4_b3_q <= b3;
    p4_x3_q <= x3;
    // Stage 5: B4 and B7.
    p5_t_q  <= p4_t_q;
    p5_st_q <= st5;
    p5_b4_q <= b4;
    p5_b7_q <= b7;
  end

  // Pressure division; the B7 top bit picks where the doubling goes.
  logic             d2_vld;
  logic [31:0]      d2_q;
  logic [Pay2W-1:0] d2_pay;
  logic [15:0]      d2_t;
  logic [1:0]       d2_st;
  logic             d2_hi;

  bsc_div #(.Width(32), .PayW(Pay2W)) u_div_p (
    .clk_i,
    .rst_ni,
    .in_valid_i  (p5_vld_q),
    .dividend_i  (p5_b7_q[31] ? p5_b7_q : (p5_b7_q << 1)),
    .divisor_i   (p5_b4_q),
    .payload_i   ({p5_t_q, p5_st_q, p5_b7_q[31]}),
    .out_valid_o (d2_vld),
    .quotient_o  (d2_q),
    .payload_o   (d2_pay)
  );

  assign {d2_t, d2_st, d2_hi} = d2_pay;

  // Final correction stages.
  logic        q1_vld_q, q2_vld_q, q3_vld_q;
  logic [15:0] q1_t_q, q2_t_q;
  logic [1:0]  q1_st_q, q2_st_q;
  logic [31:0] q1_p_q, q2_p_q;
  logic [31:0] q1_sq_q, q1_x2_q, q2_x2_q, q2_x1_q;
  logic [31:0] p_a, pp, pf;
  logic [19:0] psat;

  assign p_a = d2_hi ? (d2_q << 1) : d2_q;
  assign pp  = bsc_pkg::asr32(p_a, 8);
  assign pf  = q2_p_q + bsc_pkg::asr32(q2_x1_q + q2_x2_q + bsc_pkg::P_COEF_OFS, 4);

  always_comb begin
    if (q2_st_q != bsc_pkg::ST_OK || pf[31]) begin
      psat = 20'd0;
    end else if (pf[30:20] != 11'd0) begin
      psat = bsc_pkg::PRESS_MAX;
    end else begin
      psat = pf[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_vld_q <= 1'b0;
      q2_vld_q <= 1'b0;
      q3_vld_q <= 1'b0;
    end else begin
      q1_vld_q <= d2_vld;
      q2_vld_q <= q1_vld_q;
      q3_vld_q <= q2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_t_q  <= d2_t;
    q1_st_q <= d2_st;
    q1_p_q  <= p_a;
    q1_sq_q <= bsc_pkg::mul32(pp, pp);
    q1_x2_q <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::P_COEF_LIN, p_a), 16);
    q2_t_q  <= q1_t_q;
    q2_st_q <= q1_st_q;
    q2_p_q  <= q1_p_q;
    q2_x2_q <= q1_x2_q;
    q2_x1_q <= bsc_pkg::asr32(bsc_pkg::mul32(q1_sq_q, bsc_pkg::P_COEF_SQ), 16);
    temperature_tenths_o <= (q2_st_q == bsc_pkg::ST_NOCAL) ? 16'sd0 : $signed(q2_t_q);
    pressure_pa_o        <= psat;
    status_o             <= q2_st_q;
  end

  assign done_o = q3_vld_q;

endmodule

// ----- sv/baro_sensor_compensation_core.sv -----
// Top level of the barometric compensation core: register port, front, queue and back.
// Throughput: one transaction per cycle; busy stays low since the back part never stalls.
// The latency is mostly that of the two 32-stage divider pipelines (temperature and pressure).
// Reset (rst_ni low, asynchronous) clears all valid bits, the queue and the registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
module baro_sensor_compensation_core #(
  parameter int unsigned QueueDepth = bsc_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        raw_temperature_i,
  input  logic [23:0]        raw_pressure_bytes_i,
  output logic               done_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic [19:0]        pressure_pa_o,
  output logic [1:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
  logic [1:0]  oss_q;
  logic        cal_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_ac2_q <= '0;
      ac3_ac4_q <= '0;
      ac5_ac6_q <= '0;
      b1_b2_q   <= '0;
      mc_md_q   <= '0;
      oss_q     <= '0;
      cal_q     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        bsc_pkg::REG_AC1_AC2: ac1_ac2_q <= pwdata;
        bsc_pkg::REG_AC3_AC4: ac3_ac4_q <= pwdata;
        bsc_pkg::REG_AC5_AC6: ac5_ac6_q <= pwdata;
        bsc_pkg::REG_B1_B2:   b1_b2_q   <= pwdata;
        bsc_pkg::REG_MC_MD:   mc_md_q   <= pwdata;
        bsc_pkg::REG_OSS:     oss_q     <= pwdata[1:0];
        bsc_pkg::REG_CAL:     cal_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      bsc_pkg::REG_AC1_AC2: prdata = ac1_ac2_q;
      bsc_pkg::REG_AC3_AC4: prdata = ac3_ac4_q;
      bsc_pkg::REG_AC5_AC6: prdata = ac5_ac6_q;
      bsc_pkg::REG_B1_B2:   prdata = b1_b2_q;
      bsc_pkg::REG_MC_MD:   prdata = mc_md_q;
      bsc_pkg::REG_OSS:     prdata = {30'd0, oss_q};
      bsc_pkg::REG_CAL:     prdata = {31'd0, cal_q};
      default:              prdata = 32'd0;
    endcase
  end

  logic                  accept;
  logic                  push;
  logic                  q_full;
  logic                  q_nonempty;
  bsc_pkg::queue_entry_t front_entry;
  bsc_pkg::queue_entry_t back_entry;

  assign busy   = q_full;
  assign accept = start && !busy;

  bsc_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i             (accept),
    .raw_temperature_i,
    .raw_pressure_bytes_i,
    .coef_ac5_ac6_i       (ac5_ac6_q),
    .coef_mc_md_i         (mc_md_q),
    .cal_loaded_i         (cal_q),
    .push_o               (push),
    .entry_o              (front_entry)
  );

  bsc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .entry_i    (front_entry),
    .pop_i      (1'b1),
    .nonempty_o (q_nonempty),
    .full_o     (q_full),
    .entry_o    (back_entry)
  );

  bsc_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i        (q_nonempty),
    .entry_i        (back_entry),
    .coef_ac1_ac2_i (ac1_ac2_q),
    .coef_ac3_ac4_i (ac3_ac4_q),
    .coef_b1_b2_i   (b1_b2_q),
    .coef_mc_md_i   (mc_md_q),
    .oss_i          (oss_q),
    .done_o,
    .temperature_tenths_o,
    .pressure_pa_o,
    .status_o
  );

`ifndef NO_ASSERTIONS
  // The back part drains the queue every cycle, so it never fills.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !q_full)
    else $error("transaction queue filled up");

  // A missing calibration yields zero temperature and pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bsc_pkg::ST_NOCAL) |->
      (temperature_tenths_o == 16'sd0 && pressure_pa_o == 20'd0))
    else $error("uncalibrated transaction returned nonzero values");

  // A zero divisor always reports zero pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bsc_pkg::ST_ZDIV) |-> (pressure_pa_o == 20'd0))
    else $error("zero divisor transaction returned nonzero pressure");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the barometric compensation core.
module testbench;

  localparam int unsigned LATENCY   = 74;
  localparam int unsigned WATCHDOG  = 20000;
  localparam int unsigned N_RANDOM  = 1850;

  // One expected compensation result.
  typedef struct packed {
    logic signed [15:0] temp;
    logic [19:0]        press;
    logic [1:0]         status;
  } comp_result_t;

  // One directed stimulus row; check_fixed marks rows with a typed-in result.
  typedef struct {
    logic [15:0]  ut;
    logic [23:0]  rawp;
    bit           check_fixed;
    comp_result_t fixed;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] raw_temperature_i = '0;
  logic [23:0] raw_pressure_bytes_i = '0;
  logic        done_o;
  logic signed [15:0] temperature_tenths_o;
  logic [19:0] pressure_pa_o;
  logic [1:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  baro_sensor_compensation_core dut (
    .clk_i, .rst_ni, .start, .busy, .raw_temperature_i, .raw_pressure_bytes_i,
    .done_o, .temperature_tenths_o, .pressure_pa_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the calibration registers.
  logic [31:0] cal_regs [0:4];
  logic [1:0]  cal_oss;
  logic        cal_valid;

  comp_result_t pending_results [$];
  int unsigned  error_count;
  int unsigned  idle_cycles;
  int unsigned  send_idle_pct;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  // Computes the compensated temperature, pressure and status for one reading.
  function automatic comp_result_t compensate(input logic [15:0] ut, input logic [23:0] rawp);
    comp_result_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b5, b6, b3, b4, b7, p, t, up, sq;
    int signed ts, ps;
    r = '0;
    if (!cal_valid) begin
      r.status = bsc_pkg::ST_NOCAL;
      return r;
    end
    ac1 = sx(cal_regs[0][31:16]); ac2 = sx(cal_regs[0][15:0]);
    ac3 = sx(cal_regs[1][31:16]); ac4 = {16'd0, cal_regs[1][15:0]};
    ac5 = {16'd0, cal_regs[2][31:16]}; ac6 = {16'd0, cal_regs[2][15:0]};
    b1 = sx(cal_regs[3][31:16]); b2 = sx(cal_regs[3][15:0]);
    mc = sx(cal_regs[4][31:16]); md = sx(cal_regs[4][15:0]);
    // Temperature part.
    x1 = asr(({16'd0, ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.status = bsc_pkg::ST_ZDIV;
      return r;
    end
    // The only overflowing quotient is -2^31 / -1, which wraps back to -2^31.
    if ((mc << 11) == 32'h8000_0000 && den == 32'hFFFF_FFFF) x2 = 32'h8000_0000;
    else x2 = $unsigned($signed(mc << 11) / $signed(den));
    b5 = x1 + x2;
    t = asr(b5 + 32'd8, 4);
    ts = $signed(t);
    if (ts > 32767) ts = 32767;
    if (ts < -32768) ts = -32768;
    r.temp = ts[15:0];
    // Pressure part.
    up = {8'd0, rawp} >> (8 - cal_oss);
    b6 = b5 - 32'd4000;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.status = bsc_pkg::ST_ZDIV;
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> cal_oss);
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * 32'd3038, 16);
    x2 = asr((32'd0 - 32'd7357) * p, 16);
    p = p + asr(x1 + x2 + 32'd3791, 4);
    ps = $signed(p);
    if (ps < 0) r.press = '0;
    else if (p > 32'd1048575) r.press = 20'hF_FFFF;
    else r.press = p[19:0];
    r.status = bsc_pkg::ST_OK;
    return r;
  endfunction

  // Writes one register through the APB port and mirrors it.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bsc_pkg::REG_OSS: cal_oss = val[1:0];
      bsc_pkg::REG_CAL: cal_valid = val[0];
      default: cal_regs[idx] = val;
    endcase
    // Idling after each write keeps back-to-back writes apart.
    @(posedge clk_i);
  endtask

  // Loads a full calibration set.
  task automatic load_cal(input logic [31:0] r0, input logic [31:0] r1,
                          input logic [31:0] r2, input logic [31:0] r3,
                          input logic [31:0] r4, input logic [1:0] oss,
                          input logic cal);
    write_reg(bsc_pkg::REG_AC1_AC2, r0); write_reg(bsc_pkg::REG_AC3_AC4, r1);
    write_reg(bsc_pkg::REG_AC5_AC6, r2); write_reg(bsc_pkg::REG_B1_B2, r3);
    write_reg(bsc_pkg::REG_MC_MD, r4); write_reg(bsc_pkg::REG_OSS, {30'd0, oss});
    write_reg(bsc_pkg::REG_CAL, {31'd0, cal});
  endtask

  // Waits until every expected result has come, plus the pipeline depth.
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Sends one reading; start stays high across back-to-back transactions.
  task automatic send(input logic [15:0] ut, input logic [23:0] rawp,
                      input bit check_fixed, input comp_result_t fixed);
    comp_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    raw_temperature_i <= ut;
    raw_pressure_bytes_i <= rawp;
    do @(posedge clk_i); while (busy);
    want = compensate(ut, rawp);
    if (check_fixed && want != fixed) report_mismatch("directed row", 32'(want), 32'(fixed));
    pending_results.push_back(check_fixed ? fixed : want);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    comp_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", {30'd0, status_o}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (temperature_tenths_o !== want.temp)
          report_mismatch("temperature", {16'd0, temperature_tenths_o}, {16'd0, want.temp});
        if (pressure_pa_o !== want.press)
          report_mismatch("pressure", {12'd0, pressure_pa_o}, {12'd0, want.press});
        if (status_o !== want.status)
          report_mismatch("status", {30'd0, status_o}, {30'd0, want.status});
      end
    end
  end

  // Watchdog on cycles without any accepted transaction, result or register access.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("testbench: errors");
      $finish;
    end
  end

  stim_row_t rows [$];
  logic [31:0] std_cal [0:4];

  initial begin
    comp_result_t zero_res;
    stim_row_t row;
    int unsigned phase;
    error_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    cal_valid = 1'b0;
    cal_oss = '0;
    for (int i = 0; i < 5; i++) cal_regs[i] = '0;
    // Datasheet example coefficients.
    std_cal[0] = {16'd408, 16'hFFB8};          // AC1 408, AC2 -72
    std_cal[1] = {16'hC7D1, 16'd32741};        // AC3 -14383, AC4 32741
    std_cal[2] = {16'd32757, 16'd23153};       // AC5, AC6
    std_cal[3] = {16'd6190, 16'd4};            // B1, B2
    std_cal[4] = {16'hDDF9, 16'd2868};         // MC -8711, MD 2868
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Calibration not loaded after reset: everything zero with status NOCAL.
    zero_res = '0;
    zero_res.status = bsc_pkg::ST_NOCAL;
    send(16'h0000, 24'h000000, 1'b1, zero_res);
    send(16'hFFFF, 24'hFFFFFF, 1'b1, zero_res);
    drain();

    // Zero temperature divisor: all-zero coefficients with calibration set.
    load_cal('0, '0, '0, '0, '0, 2'd0, 1'b1);
    zero_res.status = bsc_pkg::ST_ZDIV;
    send(16'd27898, 24'h5D23_00, 1'b1, zero_res);
    drain();

    // Datasheet example: 15.0 degrees and 69964 Pa.
    load_cal(std_cal[0], std_cal[1], std_cal[2], std_cal[3], std_cal[4], 2'd0, 1'b1);
    rows.delete();
    row.check_fixed = 1'b1;
    row.fixed = '{temp: 16'sd150, press: 20'd69964, status: bsc_pkg::ST_OK};
    row.ut = 16'd27898; row.rawp = 24'd23843 << 8;
    rows.push_back(row);
    row.check_fixed = 1'b0;
    row.fixed = '0;
    foreach (rows[i]) send(rows[i].ut, rows[i].rawp, rows[i].check_fixed, rows[i].fixed);
    // Extremes of both fields.
    rows.delete();
    for (int i = 0; i < 16; i++) begin
      row.ut = (i & 1) ? 16'hFFFF : 16'h0000;
      row.rawp = (i & 2) ? 24'hFFFFFF : ((i & 4) ? 24'h800000 : 24'h000001);
      if (i & 8) row.ut = 16'h8000 ^ row.ut[0];
      rows.push_back(row);
    end
    foreach (rows[i]) send(rows[i].ut, rows[i].rawp, 1'b0, row.fixed);
    drain();

    // Zero pressure divisor: AC4 zero keeps temperature and flags status.
    load_cal(std_cal[0], std_cal[1] & 32'hFFFF_0000, std_cal[2], std_cal[3],
             std_cal[4], 2'd3, 1'b1);
    send(16'd27898, 24'h123456, 1'b0, zero_res);
    send(16'hFFFF, 24'hFFFFFF, 1'b0, zero_res);
    drain();

    // Random part over several calibration settings and idling profiles.
    for (phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: send_idle_pct = 33;
        1: send_idle_pct = 53;
        default: send_idle_pct = 0;
      endcase
      if (phase == 5)
        load_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom), 1'b1);
      else if (phase == 4)
        load_cal('1, '1, '1, '1, '1, 2'd3, 1'b1);
      else
        load_cal(std_cal[0] ^ ($urandom & 32'h00FF_00FF), std_cal[1],
                 std_cal[2] ^ ($urandom & 32'h00FF_00FF), std_cal[3], std_cal[4],
                 2'(phase), 1'b1);
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        if ($urandom_range(3) == 0)
          send(16'($urandom), 24'($urandom), 1'b0, zero_res);
        else
          send(16'($urandom_range(20000, 35000)), 24'($urandom_range(20000, 45000) << 8)
               | 24'($urandom_range(255)), 1'b0, zero_res);
      end
      drain();
    end
    // Calibration cleared again.
    write_reg(bsc_pkg::REG_CAL, 32'd0);
    send(16'($urandom), 24'($urandom), 1'b0, zero_res);
    drain();

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
